// File: design/psv_pkg.sv
// Shared types, constants and arithmetic helpers for the positional stereo volume block.
package psv_pkg;

	localparam int COORD_BITS = 13;
	localparam int POS_BITS = COORD_BITS + 1;
	localparam int DIST_BITS = COORD_BITS + 2;
	localparam int NUM_STAGES = 7;

	localparam int MAX_LOUD = 32000;
	localparam int DESCENT = 8000;
	localparam int HEAR_LIMIT = 8;

	localparam logic [0:0] CFG_VIEW_DIRECTION = 1'b0;
	localparam logic [0:0] CFG_MASTER_VOLUME = 1'b1;

	localparam logic [1:0] SIDE_NORTH = 2'd0;
	localparam logic [1:0] SIDE_EAST = 2'd1;
	localparam logic [1:0] SIDE_SOUTH = 2'd2;
	localparam logic [1:0] SIDE_WEST = 2'd3;
	localparam logic signed [2:0] SIDE_DEFAULT = -3'sd1;

	localparam logic [6:0] VOL_MAX = 7'd100;
	localparam logic [7:0] MASTER_RESET = 8'd255;

	// Reciprocals rounded up; exact for the small numerators used here.
	localparam logic [15:0] RECIP3 = 16'd21846;
	localparam logic [15:0] RECIP5 = 16'd13108;
	localparam logic [15:0] RECIP6 = 16'd10923;
	localparam logic [15:0] RECIP7 = 16'd9363;
	localparam logic [22:0] RECIP100 = 23'd5368710;

	// Loudness is only positive below the hearing limit, so eight entries cover it.
	localparam logic [14:0] LOUD_TBL [HEAR_LIMIT] = '{
		15'(MAX_LOUD - (DESCENT * 8 * 0) / (8 + 0)),
		15'(MAX_LOUD - (DESCENT * 8 * 1) / (8 + 1)),
		15'(MAX_LOUD - (DESCENT * 8 * 2) / (8 + 2)),
		15'(MAX_LOUD - (DESCENT * 8 * 3) / (8 + 3)),
		15'(MAX_LOUD - (DESCENT * 8 * 4) / (8 + 4)),
		15'(MAX_LOUD - (DESCENT * 8 * 5) / (8 + 5)),
		15'(MAX_LOUD - (DESCENT * 8 * 6) / (8 + 6)),
		15'(MAX_LOUD - (DESCENT * 8 * 7) / (8 + 7))
	};

	typedef struct packed {
		logic [4:0] tag;
		logic rel;
		logic signed [POS_BITS-1:0] x;
		logic signed [POS_BITS-1:0] y;
		logic [6:0] vol;
		logic [14:0] loud;
		logic signed [7:0] bal;
		logic [21:0] prod;
		logic [14:0] lvl;
		logic [14:0] left;
		logic [14:0] right;
	} item_t;

	function automatic logic [8:0] div_small(input logic [8:0] n, input logic [2:0] m);
		logic [24:0] p;
		begin
			p = '0;
			case (m)
				3'd1: p = {n, 16'd0};
				3'd2: p = {1'b0, n, 15'd0};
				3'd3: p = 25'(n) * 25'(RECIP3);
				3'd4: p = {2'b0, n, 14'd0};
				3'd5: p = 25'(n) * 25'(RECIP5);
				3'd6: p = 25'(n) * 25'(RECIP6);
				3'd7: p = 25'(n) * 25'(RECIP7);
				default: p = '0;
			endcase
			return p[24:16];
		end
	endfunction

	function automatic logic [14:0] div100(input logic [21:0] p);
		logic [44:0] t;
		begin
			t = 45'(p) * 45'(RECIP100);
			return t[43:29];
		end
	endfunction

endpackage

// File: design/psv_cell.sv
// One elastic pipeline cell: holds an item and passes it on when the next cell can take it.
module psv_cell (
	input logic clk,
	input logic arst_n,
	input logic up_valid,
	output logic up_ready,
	input psv_pkg::item_t up_item,
	output logic dn_valid,
	input logic dn_ready,
	output psv_pkg::item_t dn_item
);

	logic valid_q;
	psv_pkg::item_t item_q;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_q <= up_item;
		end
	end

endmodule

// File: design/positional_stereo_volume_top.sv
// Top level of the positional stereo volume block: a chain of seven pipeline cells.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  request  | req_valid / req_ready | channel_tag, offset_x, offset_y, source_side,
//           |                       | volume_percent
//  result   | rsp_valid / rsp_ready | result_tag, left_level, right_level, release_flag
//  config   | cfg_we                | cfg_index, cfg_data
//
// One request enters per cycle while the chain is not stalled. Each request passes
// through the seven cells in order; side step, distance, balance, loudness divide,
// attenuation multiply, side split and master volume each own one cell.
// Reset empties every cell and loads view direction 0 and master volume 255.
// A stalled result holds the last cell; earlier cells keep filling until the chain is full.
module positional_stereo_volume_top (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input logic [4:0] channel_tag,
	input logic signed [psv_pkg::COORD_BITS-1:0] offset_x,
	input logic signed [psv_pkg::COORD_BITS-1:0] offset_y,
	input logic signed [2:0] source_side,
	input logic [6:0] volume_percent,
	output logic rsp_valid,
	input logic rsp_ready,
	output logic [4:0] result_tag,
	output logic [14:0] left_level,
	output logic [14:0] right_level,
	output logic release_flag,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data
);

	logic [1:0] view_q;
	logic [7:0] master_q;

	psv_pkg::item_t cell_in [psv_pkg::NUM_STAGES];
	psv_pkg::item_t cell_out [psv_pkg::NUM_STAGES];
	logic cell_vld [psv_pkg::NUM_STAGES];
	logic cell_rdy [psv_pkg::NUM_STAGES];

	logic [1:0] side;
	logic signed [psv_pkg::POS_BITS-1:0] xn, yn;
	logic [psv_pkg::POS_BITS-1:0] ax, ay;
	logic [psv_pkg::DIST_BITS-1:0] man_dist;
	logic signed [3:0] xl, yl, xr, yr, xb, yb;
	logic [2:0] bx, by;
	logic [8:0] quo;
	logic [6:0] fac;
	logic [22:0] lm, rm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q <= '0;
			master_q <= psv_pkg::MASTER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				psv_pkg::CFG_VIEW_DIRECTION: view_q <= cfg_data[1:0];
				psv_pkg::CFG_MASTER_VOLUME: master_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		// Cell 0: negate the offset, step it toward the facing side, clamp the volume.
		cell_in[0] = '0;
		cell_in[0].tag = channel_tag;
		side = (source_side == psv_pkg::SIDE_DEFAULT) ? view_q : source_side[1:0];
		xn = -psv_pkg::POS_BITS'(offset_x);
		yn = -psv_pkg::POS_BITS'(offset_y);
		if (side == psv_pkg::SIDE_EAST && xn >= 0) xn = xn + psv_pkg::POS_BITS'(1);
		if (side == psv_pkg::SIDE_WEST && xn <= 0) xn = xn - psv_pkg::POS_BITS'(1);
		if (side == psv_pkg::SIDE_SOUTH && yn >= 0) yn = yn + psv_pkg::POS_BITS'(1);
		if (side == psv_pkg::SIDE_NORTH && yn <= 0) yn = yn - psv_pkg::POS_BITS'(1);
		cell_in[0].x = xn;
		cell_in[0].y = yn;
		cell_in[0].vol = (volume_percent > psv_pkg::VOL_MAX) ? psv_pkg::VOL_MAX : volume_percent;

		// Cell 1: Manhattan distance, loudness lookup, rotation by view direction.
		cell_in[1] = cell_out[0];
		ax = cell_out[0].x[psv_pkg::POS_BITS-1] ? -cell_out[0].x : cell_out[0].x;
		ay = cell_out[0].y[psv_pkg::POS_BITS-1] ? -cell_out[0].y : cell_out[0].y;
		man_dist = psv_pkg::DIST_BITS'(ax) + psv_pkg::DIST_BITS'(ay);
		cell_in[1].rel = (man_dist >= psv_pkg::DIST_BITS'(psv_pkg::HEAR_LIMIT));
		cell_in[1].loud = psv_pkg::LOUD_TBL[man_dist[2:0]];
		xl = cell_out[0].x[3:0];
		yl = cell_out[0].y[3:0];
		case (view_q)
			2'd0: begin xr = xl; yr = yl; end
			2'd1: begin xr = yl; yr = -xl; end
			2'd2: begin xr = -xl; yr = -yl; end
			2'd3: begin xr = -yl; yr = xl; end
			default: begin xr = xl; yr = yl; end
		endcase
		cell_in[1].x = psv_pkg::POS_BITS'(xr);
		cell_in[1].y = psv_pkg::POS_BITS'(yr);

		// Cell 2: balance from the rotated offset, loudness times volume.
		cell_in[2] = cell_out[1];
		xb = cell_out[1].x[3:0];
		yb = cell_out[1].y[3:0];
		bx = xb[3] ? 3'(-xb) : xb[2:0];
		by = yb[3] ? 3'(-yb) : yb[2:0];
		if (bx > by) begin
			quo = psv_pkg::div_small(9'(by) * 9'd50, bx);
			cell_in[2].bal = xb[3] ? 8'(-8'sd100 + $signed({1'b0, quo[6:0]}))
				: 8'(8'sd100 - $signed({1'b0, quo[6:0]}));
		end else if (by != 3'd0) begin
			quo = psv_pkg::div_small(9'(bx) * 9'd50, by);
			cell_in[2].bal = xb[3] ? -$signed({1'b0, quo[6:0]}) : $signed({1'b0, quo[6:0]});
		end else begin
			quo = '0;
			cell_in[2].bal = '0;
		end
		cell_in[2].prod = 22'(cell_out[1].loud) * 22'(cell_out[1].vol);

		// Cell 3: scaled loudness.
		cell_in[3] = cell_out[2];
		cell_in[3].lvl = psv_pkg::div100(cell_out[2].prod);

		// Cell 4: loudness times the attenuation of the quieter side.
		cell_in[4] = cell_out[3];
		fac = cell_out[3].bal[7] ? 7'(8'sd100 + cell_out[3].bal)
			: 7'(8'sd100 - cell_out[3].bal);
		cell_in[4].prod = 22'(cell_out[3].lvl) * 22'(fac);

		// Cell 5: split into left and right.
		cell_in[5] = cell_out[4];
		if (cell_out[4].bal[7]) begin
			cell_in[5].left = psv_pkg::div100(cell_out[4].prod);
			cell_in[5].right = cell_out[4].lvl;
		end else begin
			cell_in[5].left = cell_out[4].lvl;
			cell_in[5].right = psv_pkg::div100(cell_out[4].prod);
		end

		// Cell 6: master volume; a released source gives silence.
		cell_in[6] = cell_out[5];
		lm = 23'(cell_out[5].left) * 23'(master_q);
		rm = 23'(cell_out[5].right) * 23'(master_q);
		cell_in[6].left = cell_out[5].rel ? '0 : lm[22:8];
		cell_in[6].right = cell_out[5].rel ? '0 : rm[22:8];
	end

	for (genvar k = 0; k < psv_pkg::NUM_STAGES; k++) begin : g_cell
		logic up_v;
		logic dn_r;
		if (k == 0) begin : g_first
			assign up_v = req_valid;
			assign req_ready = cell_rdy[k];
		end else begin : g_mid
			assign up_v = cell_vld[k-1];
		end
		if (k == psv_pkg::NUM_STAGES - 1) begin : g_last
			assign dn_r = rsp_ready;
		end else begin : g_next
			assign dn_r = cell_rdy[k+1];
		end
		psv_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(up_v),
			.up_ready(cell_rdy[k]),
			.up_item(cell_in[k]),
			.dn_valid(cell_vld[k]),
			.dn_ready(dn_r),
			.dn_item(cell_out[k])
		);
	end

	assign rsp_valid = cell_vld[psv_pkg::NUM_STAGES-1];
	assign result_tag = cell_out[psv_pkg::NUM_STAGES-1].tag;
	assign left_level = cell_out[psv_pkg::NUM_STAGES-1].left;
	assign right_level = cell_out[psv_pkg::NUM_STAGES-1].right;
	assign release_flag = cell_out[psv_pkg::NUM_STAGES-1].rel;

endmodule

// File: design/psv_checker.sv
// Port-level checks for the positional stereo volume block, bound to the top level.
module psv_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic [4:0] channel_tag,
	input logic signed [psv_pkg::COORD_BITS-1:0] offset_x,
	input logic signed [psv_pkg::COORD_BITS-1:0] offset_y,
	input logic signed [2:0] source_side,
	input logic [6:0] volume_percent,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [4:0] result_tag,
	input logic [14:0] left_level,
	input logic [14:0] right_level,
	input logic release_flag,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data
);

	// A released source must be silent on both sides.
	a_release_silent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && release_flag |-> left_level == 15'd0 && right_level == 15'd0)
		else $error("released source with nonzero level");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> left_level <= 15'(psv_pkg::MAX_LOUD)
			&& right_level <= 15'(psv_pkg::MAX_LOUD))
		else $error("level above full scale");

	// A result that is not taken must stay on the port with its tag and levels unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_tag)
			&& $stable(left_level) && $stable(right_level))
		else $error("stalled result changed");

endmodule

bind positional_stereo_volume_top psv_checker u_psv_checker (.*);
